// ===== rtl/i2a_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII converter.
// No dependencies; i2a_front, i2a_back and the top level import this package.
package i2a_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int ADDR_W      = $clog2(VALUE_WIDTH);
   localparam int STEP_W      = $clog2(VALUE_WIDTH);
   localparam int DIGIT_W     = 4;
   localparam int BASE_W      = 5;
   localparam int CHAR_W      = 8;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LETTER_A = 8'h41;

   localparam logic [BASE_W-1:0] BASE_MIN     = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX     = 5'd16;
   localparam logic [BASE_W-1:0] DECIMAL_BASE = 5'd10;
   localparam logic [BASE_W-1:0] BASE_RESET   = 5'd10;

   // register index of number_base
   localparam logic REG_NUMBER_BASE = 1'b0;

   // classified job handed from front to back
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] mag;
      logic [BASE_W-1:0]      base;
      logic                   neg;
   } job_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (dx < CHAR_W'(DECIMAL_BASE))
         return CH_ZERO + dx;
      else
         return CH_LETTER_A + dx - CHAR_W'(DECIMAL_BASE);
   endfunction

endpackage

// ===== rtl/i2a_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2a_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2a_front.sv =====
// Front end: accepts input beats, clamps the base, applies the base-ten sign
// rule and queues classified jobs (two entries) for the back end. Uses i2a_pkg.
module i2a_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [i2a_pkg::VALUE_WIDTH-1:0]    value,
   input  logic [i2a_pkg::BASE_W-1:0]         number_base,
   output logic                               job_valid,
   output i2a_pkg::job_type                   job,
   input  logic                               job_take
);
   import i2a_pkg::*;

   job_type          q_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;
   logic [BASE_W-1:0] eff_base;
   job_type          cls;

   // classification
   always_comb begin
      if (number_base < BASE_MIN)
         eff_base = BASE_MIN;
      else if (number_base > BASE_MAX)
         eff_base = BASE_MAX;
      else
         eff_base = number_base;
      cls.base = eff_base;
      cls.neg  = (eff_base == DECIMAL_BASE) && value[VALUE_WIDTH-1];
      cls.mag  = cls.neg ? (~value + 1'b1) : value;
   end

   assign full      = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = job_take && job_valid;

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/i2a_back.sv =====
// Back end: emits any '-' sign, then a bit-serial divider writes digits into the
// digit RAM, then a reverse read-out fills a two-entry result queue. Uses i2a_pkg and i2a_ram.
module i2a_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  i2a_pkg::job_type                  job,
   output logic                              job_take,
   output logic                              empty,
   input  logic                              pop,
   output logic [i2a_pkg::CHAR_W-1:0]        char_code,
   output logic                              last_char
);
   import i2a_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SIGN = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       dcnt_ff, dcnt_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   rd_last_ff, rd_last_in;

   // divider datapath
   logic [BASE_W-1:0]      rem_sh;
   logic                   ge;
   logic [BASE_W-1:0]      rem_sub;
   logic [VALUE_WIDTH-1:0] quo_new;
   logic [DIGIT_W-1:0]     rem_new;

   // RAM
   logic                   ram_we, ram_re;
   logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [DIGIT_W-1:0]     ram_rdata;

   // result queue
   logic [CHAR_W-1:0]      oq_char_ff [2];
   logic                   oq_last_ff [2];
   logic                   owptr_ff, owptr_in, orptr_ff, orptr_in;
   logic [1:0]             ocnt_ff, ocnt_in;
   logic                   o_push, o_pop;
   logic [CHAR_W-1:0]      o_char;
   logic                   o_last;
   logic                   room;

   assign rem_sh  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign ge      = (rem_sh >= base_ff);
   assign rem_sub = ge ? (rem_sh - base_ff) : rem_sh;
   assign rem_new = rem_sub[DIGIT_W-1:0];
   assign quo_new = {quo_ff[VALUE_WIDTH-2:0], ge};

   // space for one more beat, counting a read in flight
   assign room = (ocnt_ff == 2'd0) || ((ocnt_ff == 2'd1) && !rd_pend_ff);

   always_comb begin
      state_in   = state_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      base_in    = base_ff;
      step_in    = step_ff;
      dcnt_in    = dcnt_ff;
      rd_pend_in = 1'b0;
      rd_last_in = rd_last_ff;
      job_take   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = dcnt_ff[ADDR_W-1:0];
      ram_re     = 1'b0;
      ram_raddr  = ADDR_W'(dcnt_ff - 1'b1);
      o_push     = 1'b0;
      o_char     = digit_char(ram_rdata);
      o_last     = rd_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               quo_in   = job.mag;
               base_in  = job.base;
               rem_in   = '0;
               step_in  = '0;
               dcnt_in  = '0;
               state_in = job.neg ? ST_SIGN : ST_DIV;
            end
         end
         ST_SIGN: begin
            if (ocnt_ff != 2'd2) begin
               o_push   = 1'b1;
               o_char   = CH_MINUS;
               o_last   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in  = quo_new;
            rem_in  = rem_new;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_WIDTH - 1)) begin
               ram_we  = 1'b1;
               dcnt_in = dcnt_ff + 1'b1;
               rem_in  = '0;
               step_in = '0;
               if (quo_new == '0 || dcnt_ff == CNT_W'(VALUE_WIDTH - 1))
                  state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rd_pend_ff) begin
               o_push = 1'b1;
            end
            if (dcnt_ff != '0) begin
               if (room) begin
                  ram_re     = 1'b1;
                  rd_pend_in = 1'b1;
                  rd_last_in = (dcnt_ff == CNT_W'(1));
                  dcnt_in    = dcnt_ff - 1'b1;
               end
            end else if (!rd_pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   i2a_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_WIDTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (rem_new),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // result queue
   assign empty     = (ocnt_ff == 2'd0);
   assign o_pop     = pop && !empty;
   assign char_code = oq_char_ff[orptr_ff];
   assign last_char = oq_last_ff[orptr_ff];

   always_comb begin
      owptr_in = owptr_ff ^ o_push;
      orptr_in = orptr_ff ^ o_pop;
      ocnt_in  = ocnt_ff + {1'b0, o_push} - {1'b0, o_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         owptr_ff   <= 1'b0;
         orptr_ff   <= 1'b0;
         ocnt_ff    <= 2'd0;
         step_ff    <= '0;
         dcnt_ff    <= '0;
         quo_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         owptr_ff   <= owptr_in;
         orptr_ff   <= orptr_in;
         ocnt_ff    <= ocnt_in;
         step_ff    <= step_in;
         dcnt_ff    <= dcnt_in;
         quo_ff     <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      base_ff    <= base_in;
      rd_last_ff <= rd_last_in;
      if (o_push) begin
         oq_char_ff[owptr_ff] <= o_char;
         oq_last_ff[owptr_ff] <= o_last;
      end
   end

`ifndef ASSERT_OFF
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff != 2'd3)
      else $error("result queue count overflow");

   a_rd_from_emit: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff) == ST_EMIT)
      else $error("digit read issued outside read-out");

   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < base_ff))
      else $error("divider remainder not below base");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_pend_ff && dcnt_ff == '0 || $past(reset)
         || !rd_pend_ff))
      else $error("read pending while idle");
`endif

endmodule

// ===== rtl/signed_integer_to_ascii_digits.sv =====
// Top level of the integer-to-ASCII digit converter.
// Depends on i2a_pkg, i2a_front, i2a_back (which uses i2a_ram).
//
// Each input beat carries one 32-bit value; the block returns its ASCII digits
// most significant first, one character per result beat, with rsp_last_char
// set on the final one. Digits of ten and above print as 'A'..'F'. The radix
// comes from the number_base register (byte address 0, reset 10); values
// below 2 act as 2 and values above 16 act as 16. Only base ten reads the
// value as two's complement and prints a leading '-', the most negative
// value included; other bases print the bits as unsigned, zero prints '0'.
// The radix is sampled when the value is accepted. Digits come from a
// restoring divider that resolves one quotient bit per cycle, and the
// stored digits are then read out in reverse into the result queue; the
// back end finishes one value, read-out included, before it takes the next,
// and the divider is the limit. A two-beat queue in front lets the next
// values be taken while one is being converted, and a two-beat result
// queue holds characters for a slow consumer.
module signed_integer_to_ascii_digits (
   input  logic                              clock,
   input  logic                              reset,
   // input beats
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [i2a_pkg::VALUE_WIDTH-1:0]   req_value,
   // result beats
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [i2a_pkg::CHAR_W-1:0]        rsp_char_code,
   output logic                              rsp_last_char,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [i2a_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [i2a_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [i2a_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import i2a_pkg::*;

   logic [BASE_W-1:0] base_ff, base_in;
   logic              csr_wr;
   logic              job_valid;
   logic              job_take;
   job_type           job;

   // register decode: word index is paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_NUMBER_BASE)
                       ? {{(CSR_DW-BASE_W){1'b0}}, base_ff} : '0;

   always_comb begin
      base_in = base_ff;
      if (csr_wr && csr_paddr[2] == REG_NUMBER_BASE)
         base_in = csr_pwdata[BASE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   // front: accept and classify, queue jobs
   i2a_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .value       (req_value),
      .number_base (base_ff),
      .job_valid   (job_valid),
      .job         (job),
      .job_take    (job_take)
   );

   // back: divide, store digits, read them out in reverse
   i2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .char_code (rsp_char_code),
      .last_char (rsp_last_char)
   );

endmodule
